// ===== rtl/sss_pkg.sv =====
// Shared types, constants and lookup functions for the stopwatch seven-segment scanner.
package sss_pkg;

   localparam int ADC_BITS_DEFAULT = 12;
   localparam int FS_W             = 14;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 14;

   // item kinds
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_CLEAR = 2'd1;
   localparam logic [1:0] KIND_SCAN  = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIMAL    = 2'd1;

   localparam logic [FS_W-1:0] FULL_SCALE_RESET = 14'd330;
   localparam logic [1:0]      DECIMAL_RESET    = 2'd1;

   localparam logic [7:0] BLANK_SEG   = 8'hFF;
   localparam logic [7:0] BLANK_DIGIT = 8'h00;
   localparam logic [7:0] DP_MASK     = 8'h7F;

   // floor(x / 10^k) = (x * recip) >> RECIP_SHIFT for x below 2^14
   localparam int RECIP_SHIFT = 23;

   typedef struct packed {
      logic       valid;
      logic [7:0] seg;
      logic [1:0] pos;
   } load_type;

   function automatic logic [23:0] digit_recip(logic [1:0] pos);
      logic [23:0] r;
      unique case (pos)
         2'd0: r = 24'd8389;     // thousands
         2'd1: r = 24'd83887;    // hundreds
         2'd2: r = 24'd838861;   // tens
         2'd3: r = 24'd8388608;  // ones
      endcase
      return r;
   endfunction

   // active-low segment patterns, decimal point off
   function automatic logic [7:0] seg_pattern(logic [3:0] d);
      logic [7:0] s;
      unique case (d)
         4'd0:    s = 8'hC0;
         4'd1:    s = 8'hF9;
         4'd2:    s = 8'hA4;
         4'd3:    s = 8'hB0;
         4'd4:    s = 8'h99;
         4'd5:    s = 8'h92;
         4'd6:    s = 8'h82;
         4'd7:    s = 8'hF8;
         4'd8:    s = 8'h80;
         4'd9:    s = 8'h90;
         default: s = BLANK_SEG;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/sss_serializer.sv =====
// Serial shifter: loads one 32-bit scan frame and hands it out one bit per beat.
module sss_serializer (
   input  logic              clock,
   input  logic              reset,
   input  sss_pkg::load_type load,
   output logic              load_free,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_data_bit,
   output logic              rsp_latch_after,
   output logic              rsp_last
);
   import sss_pkg::*;

   logic [31:0] frame_ff;
   logic [4:0]  count_ff;
   logic        valid_ff;
   logic        beat;
   logic        last_beat;

   assign beat      = valid_ff && !rsp_stall;
   assign last_beat = beat && (count_ff == 5'd31);
   assign load_free = !valid_ff || last_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load.valid && load_free) begin
         valid_ff <= 1'b1;
      end else if (last_beat) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load.valid && load_free) begin
         frame_ff <= {BLANK_SEG, BLANK_DIGIT, load.seg, 8'(8'd1 << load.pos)};
         count_ff <= 5'd0;
      end else if (beat) begin
         frame_ff <= {frame_ff[30:0], 1'b0};
         count_ff <= count_ff + 5'd1;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_data_bit    = frame_ff[31];
   assign rsp_latch_after = (count_ff[3:0] == 4'hF);
   assign rsp_last        = (count_ff == 5'd31);

endmodule

// ===== rtl/stopwatch_seven_segment_scanner.sv =====
// Top level of the stopwatch seven-segment scanner: time count, value pipeline, serial output.
//
// Request channel (req_*): one beat per item. A tick advances the mm:ss count, a clear
// zeroes it; both take effect at acceptance and give no response. A scan shows the digit
// under the digit pointer, either from the elapsed mmss or from the scaled converter reading
// floor(sample * full_scale / (2^ADC_BITS - 1)), and then advances the pointer.
// Response channel (rsp_*): each scan yields 32 beats of one serial bit, MSB first: a
// blanking frame (segments 0xFF, digits 0x00) then the segment byte and one-hot digit byte.
// rsp_latch_after marks the sixteenth bit of each frame, rsp_last the final bit of the scan.
// The first bit of a scan is offered after its request beat passes the input register,
// multiply, divide by the converter span, digit scaling and shifter load, in that order.
// Throughput: the output shifter sends one bit a cycle while rsp_stall is low; ticks and
// clears are taken one a cycle while the input register has room.
// When rsp_stall is high the shifter holds its bit, the four pipeline registers fill behind
// it, and req_stall rises once the input register can no longer move.
// Reset (synchronous) zeroes the count and digit pointer, loads full scale 330 and decimal
// digit 1, and empties the pipeline and shifter.
// CSR port: csr_write with csr_index/csr_wdata writes a register; unknown
// indexes are dropped. Writes are expected only while the block is idle.
module stopwatch_seven_segment_scanner #(
   parameter int ADC_BITS = sss_pkg::ADC_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic                          req_show_voltage,
   input  logic [ADC_BITS-1:0]           req_adc_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_data_bit,
   output logic                          rsp_latch_after,
   output logic                          rsp_last,
   input  logic                          csr_write,
   input  logic [sss_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sss_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sss_pkg::*;

   localparam int PW    = ADC_BITS + FS_W;
   localparam int FOLDS = 3;   // enough for ADC_BITS from 8 up
   localparam logic [PW-1:0] DIVISOR = PW'((1 << ADC_BITS) - 1);
   localparam logic [13:0]   TENTH_RECIP = 14'd6554;   // floor(t/10) = (t*6554) >> 16

   // details of a scan that ride alongside the value
   typedef struct packed {
      logic       volt;
      logic [1:0] pos;
      logic       dp;
      logic [3:0] tdig;
   } side_type;

   // configuration
   logic [FS_W-1:0] scale_ff;
   logic [1:0]      dec_ff;

   // mm:ss count kept as decimal digits, plus digit pointer
   logic [3:0] min_tens_ff, min_tens_in;
   logic [3:0] min_ones_ff, min_ones_in;
   logic [2:0] sec_tens_ff, sec_tens_in;
   logic [3:0] sec_ones_ff, sec_ones_in;
   logic [1:0] ptr_ff;

   // pipeline
   logic                s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [ADC_BITS-1:0] s1_sample_ff;
   logic [FS_W-1:0]     s1_scale_ff;
   logic [PW-1:0]       s2_prod_ff;
   logic [13:0]         s3_q_ff;
   logic [13:0]         s4_t_ff;
   side_type            s1_side_ff, s2_side_ff, s3_side_ff, s4_side_ff;
   side_type            s1_side_in;

   logic open1, open2, open3, open4;
   logic accept, scan_accept;
   logic load_free;
   logic [3:0] time_digit;

   logic [13:0]   fold_quot;
   logic [PW-1:0] fold_rem;
   logic [37:0]   scale_prod;
   logic [26:0]   tenth_prod;
   logic [10:0]   tenth;
   logic [13:0]   vdig_wide;
   logic [3:0]    digit;
   logic [7:0]    seg;
   load_type      load;

   // each stage moves when the one after it is empty or moving
   assign open4 = !s4_valid_ff || load_free;
   assign open3 = !s3_valid_ff || open4;
   assign open2 = !s2_valid_ff || open3;
   assign open1 = !s1_valid_ff || open2;

   assign req_stall   = !open1;
   assign accept      = req_valid && open1;
   assign scan_accept = accept && (req_kind == KIND_SCAN);

   // time digit under the pointer, counted from the left
   always_comb begin
      unique case (ptr_ff)
         2'd0: time_digit = min_tens_ff;
         2'd1: time_digit = min_ones_ff;
         2'd2: time_digit = {1'b0, sec_tens_ff};
         2'd3: time_digit = sec_ones_ff;
      endcase
   end

   always_comb begin
      s1_side_in.volt = req_show_voltage;
      s1_side_in.pos  = ptr_ff;
      s1_side_in.dp   = req_show_voltage && (ptr_ff == dec_ff);
      s1_side_in.tdig = time_digit;
   end

   // count update: seconds wrap at 60 into minutes, minutes wrap at 100
   always_comb begin
      min_tens_in = min_tens_ff;
      min_ones_in = min_ones_ff;
      sec_tens_in = sec_tens_ff;
      sec_ones_in = sec_ones_ff;
      if (accept && (req_kind == KIND_CLEAR)) begin
         min_tens_in = 4'd0;
         min_ones_in = 4'd0;
         sec_tens_in = 3'd0;
         sec_ones_in = 4'd0;
      end else if (accept && (req_kind == KIND_TICK)) begin
         if (sec_ones_ff != 4'd9) begin
            sec_ones_in = sec_ones_ff + 4'd1;
         end else begin
            sec_ones_in = 4'd0;
            if (sec_tens_ff != 3'd5) begin
               sec_tens_in = sec_tens_ff + 3'd1;
            end else begin
               sec_tens_in = 3'd0;
               if (min_ones_ff != 4'd9) begin
                  min_ones_in = min_ones_ff + 4'd1;
               end else begin
                  min_ones_in = 4'd0;
                  min_tens_in = (min_tens_ff == 4'd9) ? 4'd0 : min_tens_ff + 4'd1;
               end
            end
         end
      end
   end

   // divide by 2^ADC_BITS - 1: fold the high part back onto the low part
   always_comb begin
      fold_quot = '0;
      fold_rem  = s2_prod_ff;
      for (int k = 0; k < FOLDS; k++) begin
         fold_quot = fold_quot + fold_rem[PW-1:ADC_BITS];
         fold_rem  = {{FS_W{1'b0}}, fold_rem[ADC_BITS-1:0]} + PW'(fold_rem[PW-1:ADC_BITS]);
      end
      if (fold_rem >= DIVISOR) begin
         fold_quot = fold_quot + 14'd1;
         fold_rem  = fold_rem - DIVISOR;
      end
   end

   // scale to the wanted decimal position
   assign scale_prod = 38'(s3_q_ff) * 38'(digit_recip(s3_side_ff.pos));

   // take the scaled value modulo 10, then form the segment byte
   assign tenth_prod = 27'(s4_t_ff) * 27'(TENTH_RECIP);
   assign tenth      = tenth_prod[26:16];
   assign vdig_wide  = s4_t_ff - 14'({tenth, 3'b000}) - 14'({tenth, 1'b0});

   always_comb begin
      digit = s4_side_ff.volt ? vdig_wide[3:0] : s4_side_ff.tdig;
      seg   = seg_pattern(digit);
      if (s4_side_ff.dp) begin
         seg = seg & DP_MASK;
      end
   end

   assign load.valid = s4_valid_ff;
   assign load.seg   = seg;
   assign load.pos   = s4_side_ff.pos;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff    <= FULL_SCALE_RESET;
         dec_ff      <= DECIMAL_RESET;
         min_tens_ff <= 4'd0;
         min_ones_ff <= 4'd0;
         sec_tens_ff <= 3'd0;
         sec_ones_ff <= 4'd0;
         ptr_ff      <= 2'd0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               CSR_FULL_SCALE: scale_ff <= csr_wdata[FS_W-1:0];
               CSR_DECIMAL:    dec_ff   <= csr_wdata[1:0];
               default:        ;
            endcase
         end
         min_tens_ff <= min_tens_in;
         min_ones_ff <= min_ones_in;
         sec_tens_ff <= sec_tens_in;
         sec_ones_ff <= sec_ones_in;
         if (scan_accept) begin
            ptr_ff <= ptr_ff + 2'd1;
         end
         if (open1) begin
            s1_valid_ff <= scan_accept;
         end
         if (open2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (open3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (open4) begin
            s4_valid_ff <= s3_valid_ff;
         end
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (open1) begin
         s1_sample_ff <= req_adc_sample;
         s1_scale_ff  <= scale_ff;
         s1_side_ff   <= s1_side_in;
      end
      if (open2) begin
         s2_prod_ff <= PW'(s1_sample_ff) * PW'(s1_scale_ff);
         s2_side_ff <= s1_side_ff;
      end
      if (open3) begin
         s3_q_ff    <= fold_quot;
         s3_side_ff <= s2_side_ff;
      end
      if (open4) begin
         s4_t_ff    <= scale_prod[RECIP_SHIFT +: 14];
         s4_side_ff <= s3_side_ff;
      end
   end

   sss_serializer u_serializer (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .load_free       (load_free),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_data_bit    (rsp_data_bit),
      .rsp_latch_after (rsp_latch_after),
      .rsp_last        (rsp_last)
   );

`ifndef SYNTHESIS
   // pointer steps by one on every accepted scan
   a_ptr_step: assert property (@(posedge clock) disable iff (reset)
      scan_accept |=> ptr_ff == $past(ptr_ff) + 2'd1)
      else $error("digit pointer did not advance after a scan");

   // decimal count digits stay legal
   a_bcd_range: assert property (@(posedge clock) disable iff (reset)
      sec_tens_ff <= 3'd5 && sec_ones_ff <= 4'd9 && min_ones_ff <= 4'd9 &&
      min_tens_ff <= 4'd9)
      else $error("elapsed count digit out of range");

   // folding divider leaves a remainder below the divisor
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> fold_rem < DIVISOR)
      else $error("divider remainder not reduced");
`endif

endmodule
